[rtl/wdga_pkg.sv]
// Shared types and constants for the wind direction and gust averager.
// Holds field widths, stream packing, operation codes and the controller states.
// No dependencies.
package wdga_pkg;

    // Field widths
    localparam int VANE_W  = 8;
    localparam int GUST_W  = 16;
    localparam int SLOT_W  = 6;
    localparam int AVG_W   = 8;
    localparam int CNT_W   = 16;
    localparam int OP_W    = 2;

    // Log slots and the width of the slot pointer
    localparam int LOG_SLOTS  = 64;
    localparam int SLOT_PTR_W = $clog2(LOG_SLOTS);

    // Unwrapped positions stay within one turn of the raw range: -256..511
    localparam int POS_W    = 10;
    localparam int DLT_W    = 11;
    localparam int LAST_MIN = -256;
    localparam int LAST_MAX = 511;

    // 65535 samples of at most 511 fit a 26-bit signed sum, 25-bit magnitude
    localparam int SUM_W     = 26;
    localparam int MAG_W     = 25;
    localparam int DIV_CNT_W = $clog2(MAG_W);

    localparam logic [CNT_W-1:0]        CNT_MAX   = '1;
    localparam logic signed [DLT_W-1:0] HALF_TURN = DLT_W'(128);
    localparam logic signed [DLT_W-1:0] TURN      = DLT_W'(256);

    // Stream packing
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - (SLOT_W + GUST_W + AVG_W);
    localparam int OUT_USER_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 2'd0,
        OP_GUST    = 2'd1,
        OP_AVERAGE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[rtl/wind_direction_gust_averager_top.sv]
// Wind direction and gust averager: unwraps vane samples into a running sum,
// tracks the peak gust and emits a mean direction per log slot.
// Depends on wdga_pkg.
//
// A direction sample or gust end is taken while idle; the next request is taken
// in the following cycle. An average end runs the 25-step restoring divider, one
// quotient bit per cycle, then loads the output register once it is free,
// skipping the divider when the period holds no sample. One average end is in flight at a time.
// Reset (rst_n low, asynchronous) clears all sums, the slot pointer, the north
// offset and the output valid.
module wind_direction_gust_averager_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] vane_position, [23:8] gust_count
    input  logic [wdga_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] operation, [2] sample_ok
    input  logic [wdga_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] slot_index, [21:6] max_gust, [29:22] avg_direction, [31:30] zero
    output logic [wdga_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] direction_valid
    output logic [wdga_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    input  logic                             cfg_wr_en,
    input  logic [wdga_pkg::AVG_W-1:0]       cfg_wr_data
);

    // Request fields
    wdga_pkg::op_t                   op;
    logic                            sample_ok;
    logic [wdga_pkg::VANE_W-1:0]     vane;
    logic [wdga_pkg::GUST_W-1:0]     gust_in;
    logic                            accept;

    // Controller
    wdga_pkg::state_t                state_reg, state_next;
    logic                            load_out;

    // Period state
    logic [wdga_pkg::AVG_W-1:0]      north_reg;
    logic [wdga_pkg::SLOT_PTR_W-1:0] slot_reg, slot_next;
    logic [wdga_pkg::GUST_W-1:0]     gust_reg, gust_next;
    logic signed [wdga_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [wdga_pkg::POS_W-1:0] last_reg, last_next;
    logic [wdga_pkg::CNT_W-1:0]      total_reg, total_next;

    // Unwrap
    logic signed [wdga_pkg::DLT_W-1:0] pos_s;
    logic signed [wdga_pkg::DLT_W-1:0] last_ext;
    logic signed [wdga_pkg::DLT_W-1:0] delta;
    logic signed [wdga_pkg::DLT_W-1:0] unw_full;
    logic signed [wdga_pkg::POS_W-1:0] unw;
    logic                              unw_take;

    // Divider and captured result
    logic signed [wdga_pkg::SUM_W-1:0] sum_neg;
    logic signed [wdga_pkg::SUM_W-1:0] sum_abs;
    logic [wdga_pkg::MAG_W-1:0]      dvd_reg;
    logic [wdga_pkg::CNT_W-1:0]      dvs_reg;
    logic [wdga_pkg::CNT_W-1:0]      rem_reg;
    logic                            neg_reg;
    logic [wdga_pkg::DIV_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [wdga_pkg::CNT_W:0]        trial;
    logic [wdga_pkg::CNT_W:0]        diff;
    logic                            q_bit;
    logic [wdga_pkg::SLOT_W-1:0]     res_slot_reg;
    logic [wdga_pkg::GUST_W-1:0]     res_gust_reg;
    logic                            res_valid_reg;
    logic [wdga_pkg::AVG_W-1:0]      q8;
    logic [wdga_pkg::AVG_W-1:0]      mean8;
    logic [wdga_pkg::AVG_W-1:0]      avg;

    // Output register
    logic                            out_valid_reg;
    logic [wdga_pkg::SLOT_W-1:0]     out_slot_reg;
    logic [wdga_pkg::GUST_W-1:0]     out_gust_reg;
    logic                            out_dirv_reg;
    logic [wdga_pkg::AVG_W-1:0]      out_avg_reg;

    assign op        = wdga_pkg::op_t'(s_axis_tuser[wdga_pkg::OP_W-1:0]);
    assign sample_ok = s_axis_tuser[wdga_pkg::OP_W];
    assign vane      = s_axis_tdata[wdga_pkg::VANE_W-1:0];
    assign gust_in   = s_axis_tdata[wdga_pkg::VANE_W +: wdga_pkg::GUST_W];
    assign accept    = s_axis_tvalid && s_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wdga_pkg::ST_IDLE:
            begin
                if (accept && op == wdga_pkg::OP_AVERAGE)
                begin
                    state_next = (total_reg != '0) ? wdga_pkg::ST_DIV : wdga_pkg::ST_DONE;
                end
            end
            wdga_pkg::ST_DIV:
            begin
                if (bit_cnt_reg == wdga_pkg::DIV_CNT_W'(wdga_pkg::MAG_W - 1))
                begin
                    state_next = wdga_pkg::ST_DONE;
                end
            end
            wdga_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = wdga_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wdga_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            wdga_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            wdga_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
                load_out      = 1'b0;
            end
        endcase
    end

    // Unwrap the new position against the last one by at most one turn
    always_comb
    begin
        pos_s    = $signed({{(wdga_pkg::DLT_W - wdga_pkg::VANE_W){1'b0}}, vane});
        last_ext = {{(wdga_pkg::DLT_W - wdga_pkg::POS_W){last_reg[wdga_pkg::POS_W-1]}}, last_reg};
        delta    = pos_s - last_ext;
        unw_take = !(delta == wdga_pkg::HALF_TURN || delta == -wdga_pkg::HALF_TURN);
        if (delta > -wdga_pkg::HALF_TURN && delta < wdga_pkg::HALF_TURN)
        begin
            unw_full = pos_s;
        end
        else if (delta < -wdga_pkg::HALF_TURN)
        begin
            unw_full = pos_s + wdga_pkg::TURN;
        end
        else
        begin
            unw_full = pos_s - wdga_pkg::TURN;
        end
        unw = unw_full[wdga_pkg::POS_W-1:0];
    end

    // Period state update
    always_comb
    begin
        slot_next  = slot_reg;
        gust_next  = gust_reg;
        sum_next   = sum_reg;
        last_next  = last_reg;
        total_next = total_reg;
        if (accept)
        begin
            case (op)
                wdga_pkg::OP_SAMPLE:
                begin
                    if (sample_ok && total_reg != wdga_pkg::CNT_MAX)
                    begin
                        if (total_reg == '0)
                        begin
                            sum_next   = {{(wdga_pkg::SUM_W - wdga_pkg::VANE_W){1'b0}}, vane};
                            last_next  = {{(wdga_pkg::POS_W - wdga_pkg::VANE_W){1'b0}}, vane};
                            total_next = total_reg + wdga_pkg::CNT_W'(1);
                        end
                        else if (unw_take)
                        begin
                            sum_next   = sum_reg +
                                {{(wdga_pkg::SUM_W - wdga_pkg::POS_W){unw[wdga_pkg::POS_W-1]}}, unw};
                            last_next  = unw;
                            total_next = total_reg + wdga_pkg::CNT_W'(1);
                        end
                    end
                end
                wdga_pkg::OP_GUST:
                begin
                    if (gust_in > gust_reg)
                    begin
                        gust_next = gust_in;
                    end
                end
                wdga_pkg::OP_AVERAGE:
                begin
                    // Results are captured below; start the next period now
                    gust_next  = '0;
                    sum_next   = '0;
                    last_next  = '0;
                    total_next = '0;
                    if (slot_reg == wdga_pkg::SLOT_PTR_W'(wdga_pkg::LOG_SLOTS - 1))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + wdga_pkg::SLOT_PTR_W'(1);
                    end
                end
                default:
                begin
                    slot_next = slot_reg;
                end
            endcase
        end
    end

    // Restoring divider step and result formatting
    always_comb
    begin
        sum_neg = -sum_reg;
        sum_abs = sum_reg[wdga_pkg::SUM_W-1] ? sum_neg : sum_reg;
        trial   = {rem_reg, dvd_reg[wdga_pkg::MAG_W-1]};
        diff    = trial - {1'b0, dvs_reg};
        q_bit   = (trial >= {1'b0, dvs_reg});
        bit_cnt_next = bit_cnt_reg + wdga_pkg::DIV_CNT_W'(1);
        q8      = dvd_reg[wdga_pkg::AVG_W-1:0];
        mean8   = neg_reg ? (~q8 + wdga_pkg::AVG_W'(1)) : q8;
        avg     = res_valid_reg ? (mean8 - north_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wdga_pkg::ST_IDLE;
            north_reg     <= '0;
            slot_reg      <= '0;
            gust_reg      <= '0;
            sum_reg       <= '0;
            last_reg      <= '0;
            total_reg     <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            gust_reg  <= gust_next;
            sum_reg   <= sum_next;
            last_reg  <= last_next;
            total_reg <= total_next;
            if (cfg_wr_en)
            begin
                north_reg <= cfg_wr_data;
            end
            if (state_reg == wdga_pkg::ST_DIV)
            begin
                bit_cnt_reg <= bit_cnt_next;
            end
            else
            begin
                bit_cnt_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider and result payload
    always_ff @(posedge clk)
    begin
        if (accept && op == wdga_pkg::OP_AVERAGE)
        begin
            dvd_reg       <= sum_abs[wdga_pkg::MAG_W-1:0];
            neg_reg       <= sum_reg[wdga_pkg::SUM_W-1];
            dvs_reg       <= total_reg;
            rem_reg       <= '0;
            res_slot_reg  <= wdga_pkg::SLOT_W'(slot_reg);
            res_gust_reg  <= gust_reg;
            res_valid_reg <= (total_reg != '0);
        end
        else if (state_reg == wdga_pkg::ST_DIV)
        begin
            // Shift one quotient bit in while the dividend shifts out
            dvd_reg <= {dvd_reg[wdga_pkg::MAG_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[wdga_pkg::CNT_W-1:0] : trial[wdga_pkg::CNT_W-1:0];
        end
        if (load_out)
        begin
            out_slot_reg <= res_slot_reg;
            out_gust_reg <= res_gust_reg;
            out_dirv_reg <= res_valid_reg;
            out_avg_reg  <= avg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{wdga_pkg::OUT_PAD_W{1'b0}}, out_avg_reg, out_gust_reg, out_slot_reg};
    assign m_axis_tuser  = out_dirv_reg;

`ifndef SYNTH
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wdga_pkg::ST_DIV) |-> (dvs_reg != '0))
        else $error("divider running with zero sample count");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wdga_pkg::ST_DIV) |-> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

    a_period_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == wdga_pkg::OP_AVERAGE) |=> (total_reg == '0 && sum_reg == '0))
        else $error("period not cleared after average end");

    a_last_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg >= wdga_pkg::LAST_MIN) && (last_reg <= wdga_pkg::LAST_MAX))
        else $error("unwrapped position outside one turn");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Stream testbench for wind_direction_gust_averager_top: directed and random vane,
// gust and average requests checked against an in-bench averager model.
// Depends on wdga_pkg and the top-level RTL.
module testbench;

    localparam int CLK_HALF     = 5;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 465;
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    localparam int VANE_HALF_TURN = 128;
    localparam int VANE_TURN      = 256;

    // Code with no function in the block
    localparam logic [wdga_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [wdga_pkg::OP_W-1:0]   op;
        logic                        ok;
        logic [wdga_pkg::VANE_W-1:0] vane;
        logic [wdga_pkg::GUST_W-1:0] gust;
    } vane_req_t;

    typedef struct packed {
        logic [wdga_pkg::SLOT_W-1:0] slot;
        logic [wdga_pkg::GUST_W-1:0] max_gust;
        logic                        valid;
        logic [wdga_pkg::AVG_W-1:0]  avg_dir;
    } log_entry_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [wdga_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [wdga_pkg::IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [wdga_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [wdga_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic                            cfg_wr_en     = 1'b0;
    logic [wdga_pkg::AVG_W-1:0]      cfg_wr_data   = '0;

    vane_req_t  pending_reqs[$];
    log_entry_t expected_entries[$];
    vane_req_t  offer_req;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         mismatch_count = 0;
    int         reqs_added     = 0;
    bit         long_hold      = 1'b0;
    int         hold_count;

    // Averager model state
    logic [wdga_pkg::AVG_W-1:0]      north_offset   = '0;
    logic [wdga_pkg::SLOT_PTR_W-1:0] slot_pointer   = '0;
    logic [wdga_pkg::GUST_W-1:0]     gust_maximum   = '0;
    logic signed [31:0]              direction_sum  = '0;
    logic signed [15:0]              last_unwrapped = '0;
    logic [wdga_pkg::CNT_W-1:0]      sample_total   = '0;

    wind_direction_gust_averager_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #CLK_HALF clk = ~clk;

    task automatic advance_averager(input vane_req_t r);
        int         delta;
        int         unwrapped;
        int         mean;
        log_entry_t e;
        case (r.op)
            wdga_pkg::OP_SAMPLE:
            begin
                if (r.ok && sample_total != wdga_pkg::CNT_MAX)
                begin
                    if (sample_total == 0)
                    begin
                        direction_sum  = 32'(int'(r.vane));
                        last_unwrapped = 16'(int'(r.vane));
                        sample_total   = sample_total + wdga_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        delta = int'(r.vane) - int'(last_unwrapped);
                        // drop a sample exactly half a turn away
                        if (delta != VANE_HALF_TURN && delta != -VANE_HALF_TURN)
                        begin
                            if (delta > VANE_HALF_TURN)
                                unwrapped = int'(r.vane) - VANE_TURN;
                            else if (delta < -VANE_HALF_TURN)
                                unwrapped = int'(r.vane) + VANE_TURN;
                            else
                                unwrapped = int'(r.vane);
                            last_unwrapped = 16'(unwrapped);
                            direction_sum  = direction_sum + 32'(unwrapped);
                            sample_total   = sample_total + wdga_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            wdga_pkg::OP_GUST:
            begin
                if (r.gust > gust_maximum)
                    gust_maximum = r.gust;
            end
            wdga_pkg::OP_AVERAGE:
            begin
                e.slot     = wdga_pkg::SLOT_W'(slot_pointer);
                e.max_gust = gust_maximum;
                e.valid    = (sample_total != 0);
                e.avg_dir  = '0;
                if (e.valid)
                begin
                    // integer division truncates toward zero
                    mean      = int'(direction_sum) / int'(sample_total);
                    e.avg_dir = wdga_pkg::AVG_W'(mean - int'(north_offset));
                end
                expected_entries.push_back(e);
                slot_pointer   = wdga_pkg::SLOT_PTR_W'((int'(slot_pointer) + 1)
                                                       % wdga_pkg::LOG_SLOTS);
                gust_maximum   = '0;
                direction_sum  = '0;
                last_unwrapped = '0;
                sample_total   = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_log_entry();
        log_entry_t want;
        log_entry_t got;
        got.slot     = m_axis_tdata[wdga_pkg::SLOT_W-1:0];
        got.max_gust = m_axis_tdata[wdga_pkg::SLOT_W +: wdga_pkg::GUST_W];
        got.avg_dir  = m_axis_tdata[wdga_pkg::SLOT_W + wdga_pkg::GUST_W +: wdga_pkg::AVG_W];
        got.valid    = m_axis_tuser[0];
        if (expected_entries.size() == 0)
        begin
            $display("%0t: unexpected entry, expected none, got slot %0d gust %0d valid %0b dir %0d",
                     $time, got.slot, got.max_gust, got.valid, got.avg_dir);
            mismatch_count++;
        end
        else
        begin
            want = expected_entries.pop_front();
            if (got.slot != want.slot)
            begin
                $display("%0t: slot_index expected %0d got %0d", $time, want.slot, got.slot);
                mismatch_count++;
            end
            if (got.max_gust != want.max_gust)
            begin
                $display("%0t: max_gust expected %0d got %0d", $time, want.max_gust,
                         got.max_gust);
                mismatch_count++;
            end
            if (got.valid != want.valid)
            begin
                $display("%0t: direction_valid expected %0b got %0b", $time, want.valid,
                         got.valid);
                mismatch_count++;
            end
            if (got.avg_dir != want.avg_dir)
            begin
                $display("%0t: avg_direction expected %0d got %0d", $time, want.avg_dir,
                         got.avg_dir);
                mismatch_count++;
            end
            if (m_axis_tdata[wdga_pkg::OUT_DATA_W-1 -: wdga_pkg::OUT_PAD_W] != '0)
            begin
                $display("%0t: tdata pad expected 0 got %0h", $time,
                         m_axis_tdata[wdga_pkg::OUT_DATA_W-1 -: wdga_pkg::OUT_PAD_W]);
                mismatch_count++;
            end
        end
    endtask

    // Request driver: present the next pending request, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_averager(offer_req);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    offer_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offer_req.gust, offer_req.vane};
                    s_axis_tuser  <= {offer_req.ok, offer_req.op};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted once it is armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_count <= 0;
        else if (long_hold && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_log_entry();
            m_axis_tready <= !(long_hold && hold_count < HOLD_CYCLES)
                             && ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic add_req(input logic [wdga_pkg::OP_W-1:0] op, input logic ok,
                           input logic [wdga_pkg::VANE_W-1:0] vane,
                           input logic [wdga_pkg::GUST_W-1:0] gust);
        vane_req_t r;
        r.op   = op;
        r.ok   = ok;
        r.vane = vane;
        r.gust = gust;
        pending_reqs.push_back(r);
        reqs_added++;
    endtask

    // One averaging period: samples walking around the dial, gust ends, some noise
    task automatic add_period();
        int                          n;
        int                          pick;
        logic [wdga_pkg::VANE_W-1:0] vane;
        logic [wdga_pkg::GUST_W-1:0] gust;
        n    = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(30, 1);
        vane = wdga_pkg::VANE_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
            begin
                case ($urandom_range(19, 0))
                    0, 1:    vane = vane + wdga_pkg::VANE_W'(VANE_HALF_TURN);
                    2, 3, 4: vane = wdga_pkg::VANE_W'($urandom);
                    default: vane = vane + wdga_pkg::VANE_W'($urandom_range(80, 0) - 40);
                endcase
                add_req(wdga_pkg::OP_SAMPLE, $urandom_range(9, 0) != 0, vane,
                        wdga_pkg::GUST_W'($urandom));
            end
            else if (pick < 87)
            begin
                case ($urandom_range(7, 0))
                    0:       gust = '0;
                    1:       gust = '1;
                    2, 3:    gust = wdga_pkg::GUST_W'($urandom);
                    default: gust = wdga_pkg::GUST_W'($urandom_range(2000, 0));
                endcase
                add_req(wdga_pkg::OP_GUST, 1'($urandom), wdga_pkg::VANE_W'($urandom), gust);
            end
            else if (pick < 93)
                add_req(OP_SPARE, 1'($urandom), wdga_pkg::VANE_W'($urandom),
                        wdga_pkg::GUST_W'($urandom));
            else
                add_req(wdga_pkg::OP_W'($urandom), 1'($urandom), wdga_pkg::VANE_W'($urandom),
                        wdga_pkg::GUST_W'($urandom));
        end
        add_req(wdga_pkg::OP_AVERAGE, 1'($urandom), wdga_pkg::VANE_W'($urandom),
                wdga_pkg::GUST_W'($urandom));
    endtask

    task automatic add_random(input int count);
        int start;
        start = reqs_added;
        while (reqs_added - start < count)
            add_period();
    endtask

    task automatic write_north(input logic [wdga_pkg::AVG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        north_offset = value;
        @(negedge clk);
    endtask

    // Hold until every request is taken and every entry has come back, then drain
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_entries.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        send_idle_pct = 21;
        recv_idle_pct = 48;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_north(8'd37);

        // Empty period, gust extremes, ignored requests
        add_req(wdga_pkg::OP_AVERAGE, 1'b1, 8'd255, 16'hFFFF);
        add_req(wdga_pkg::OP_GUST, 1'b0, 8'd0, 16'd0);
        add_req(wdga_pkg::OP_GUST, 1'b0, 8'd0, 16'hFFFF);
        add_req(wdga_pkg::OP_GUST, 1'b1, 8'd9, 16'd1000);
        add_req(OP_SPARE, 1'b1, 8'hFF, 16'hFFFF);
        add_req(wdga_pkg::OP_SAMPLE, 1'b0, 8'd77, 16'd5);
        // Wrap below zero, then a sample half a turn away
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd0, 16'd0);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd255, 16'd0);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd127, 16'd0);
        add_req(wdga_pkg::OP_AVERAGE, 1'b0, 8'd0, 16'd0);
        // Wrap above a turn, the other half-turn case
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd255, 16'hFFFF);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd0, 16'hFFFF);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd128, 16'hFFFF);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd200, 16'hFFFF);
        add_req(wdga_pkg::OP_GUST, 1'b1, 8'd255, 16'd1);
        add_req(wdga_pkg::OP_AVERAGE, 1'b1, 8'd255, 16'hFFFF);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd128, 16'd0);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd0, 16'd0);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd255, 16'd0);
        add_req(OP_SPARE, 1'b0, 8'd0, 16'd0);
        add_req(wdga_pkg::OP_AVERAGE, 1'b0, 8'd0, 16'd0);
        // Period with a negative mean
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd10, 16'd0);
        add_req(wdga_pkg::OP_SAMPLE, 1'b1, 8'd200, 16'd0);
        add_req(wdga_pkg::OP_AVERAGE, 1'b0, 8'd0, 16'd0);
        wait_idle();

        write_north(8'd0);
        long_hold = 1'b1;
        add_random(RANDOM_ITEMS);
        wait_idle();

        send_idle_pct = 48;
        recv_idle_pct = 21;
        write_north(8'd255);
        add_random(RANDOM_ITEMS);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_north(wdga_pkg::AVG_W'($urandom));
        add_random(RANDOM_ITEMS);
        wait_idle();

        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
